// ===== rtl/kps_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keypad scanner package
// Sizes, derived widths and the item and result types shared by the keypad
// scanner modules.
// ----------------------------------------------------------------------------
package kps_pkg;

  localparam int COLUMNS    = 4;
  localparam int ROWS       = 4;
  localparam int ROW_PINS   = 4;
  localparam int DRIVE_PINS = 4;
  localparam int EVENT_BITS = 16;
  localparam int CODE_W     = 4;

  localparam int PHASE_W   = $clog2(COLUMNS + 1);
  localparam int COL_IDX_W = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int IDX_W     = $clog2(COLUMNS * ROWS + EVENT_BITS);
  localparam int ROW_USED  = (ROWS < ROW_PINS) ? ROWS : ROW_PINS;

  localparam logic [ROW_PINS-1:0] ROW_ENABLE = ROW_PINS'((1 << ROW_USED) - 1);

  typedef struct packed {
    logic [ROW_PINS-1:0]   row_levels;
    logic [EVENT_BITS-1:0] event_ack;
  } kps_item_t;

  typedef struct packed {
    logic [DRIVE_PINS-1:0] column_drive;
    logic [EVENT_BITS-1:0] event_flags;
    logic                  key_valid;
    logic [CODE_W-1:0]     key_code;
  } kps_result_t;

endpackage

// ===== rtl/matrix_keypad_scanner_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Matrix keypad scanner core
// Each item is one scan tick that yields exactly one result item. A tick is
// taken every clock cycle while the output does not stall; it passes an input
// register, the phase and decode logic, and a result register, from which its
// result drives the output ports. The single state update per tick in the
// decode logic sets that rate.
// ----------------------------------------------------------------------------
module matrix_keypad_scanner_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [kps_pkg::ROW_PINS-1:0]       in_row_levels,
  input  logic [kps_pkg::EVENT_BITS-1:0]     in_event_ack,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [kps_pkg::DRIVE_PINS-1:0]     out_column_drive,
  output logic [kps_pkg::EVENT_BITS-1:0]     out_event_flags,
  output logic                               out_key_valid,
  output logic [kps_pkg::CODE_W-1:0]         out_key_code
);

  kps_pkg::kps_item_t   in_item;
  kps_pkg::kps_item_t   item;
  logic                 item_valid;
  logic                 item_stall;
  kps_pkg::kps_result_t result;
  kps_pkg::kps_result_t out_res;

  assign in_item.row_levels = in_row_levels;
  assign in_item.event_ack  = in_event_ack;

  kps_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item)
  );

  kps_decode u_decode (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (item_valid && !item_stall),
    .item   (item),
    .result (result)
  );

  kps_out_stage u_out_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (item_valid),
    .res_stall (item_stall),
    .res       (result),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_column_drive = out_res.column_drive;
  assign out_event_flags  = out_res.event_flags;
  assign out_key_valid    = out_res.key_valid;
  assign out_key_code     = out_res.key_code;

endmodule

// ===== rtl/kps_in_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keypad scanner input register
// Holds one accepted scan tick until the decode logic consumes it.
// ----------------------------------------------------------------------------
module kps_in_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  kps_pkg::kps_item_t in_item,
  output logic              item_valid,
  input  logic              item_stall,
  output kps_pkg::kps_item_t item
);

  logic               valid_r;
  kps_pkg::kps_item_t item_r;
  logic               load;

  assign in_stall   = valid_r && item_stall;
  assign load       = !in_stall;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && in_valid) begin
      item_r <= in_item;
    end
  end

endmodule

// ===== rtl/kps_decode.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keypad scanner phase and decode logic
// Holds the scan phase, the per-column row masks, the release flag and the
// latched events, and computes one result for each consumed tick.
// ----------------------------------------------------------------------------
module kps_decode (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 fire,
  input  kps_pkg::kps_item_t   item,
  output kps_pkg::kps_result_t result
);

  logic [kps_pkg::PHASE_W-1:0]    phase_r, phase_nxt;
  logic [kps_pkg::ROW_PINS-1:0]   mask_r [kps_pkg::COLUMNS];
  logic [kps_pkg::ROW_PINS-1:0]   mask_nxt [kps_pkg::COLUMNS];
  logic                           armed_r, armed_nxt;
  logic [kps_pkg::EVENT_BITS-1:0] events_r, events_nxt;

  logic                           decode_phase;
  logic                           any_pressed;
  logic [kps_pkg::IDX_W-1:0]      first_idx;
  logic                           key_valid;
  logic [kps_pkg::DRIVE_PINS-1:0] drive;

  assign decode_phase = (phase_r == kps_pkg::PHASE_W'(kps_pkg::COLUMNS));

  always_comb begin
    any_pressed = 1'b0;
    first_idx   = '0;
    for (int c = kps_pkg::COLUMNS - 1; c >= 0; c--) begin
      for (int r = kps_pkg::ROW_PINS - 1; r >= 0; r--) begin
        if (mask_r[c][r]) begin
          any_pressed = 1'b1;
          first_idx   = kps_pkg::IDX_W'(c * kps_pkg::ROWS + r);
        end
      end
    end
  end

  always_comb begin
    phase_nxt  = phase_r;
    armed_nxt  = armed_r;
    key_valid  = 1'b0;
    events_nxt = events_r & ~item.event_ack;
    for (int c = 0; c < kps_pkg::COLUMNS; c++) begin
      mask_nxt[c] = mask_r[c];
    end

    if (!decode_phase) begin
      mask_nxt[phase_r[kps_pkg::COL_IDX_W-1:0]] = ~item.row_levels & kps_pkg::ROW_ENABLE;
      phase_nxt = phase_r + 1'b1;
    end else begin
      if (!any_pressed) begin
        armed_nxt = 1'b1;
      end else if (armed_r) begin
        armed_nxt = 1'b0;
        key_valid = (first_idx < kps_pkg::IDX_W'(kps_pkg::EVENT_BITS));
      end
      phase_nxt = '0;
      for (int c = 0; c < kps_pkg::COLUMNS; c++) begin
        mask_nxt[c] = '0;
      end
    end

    if (key_valid) begin
      events_nxt[first_idx[kps_pkg::CODE_W-1:0]] = 1'b1;
    end

    for (int p = 0; p < kps_pkg::DRIVE_PINS; p++) begin
      drive[p] = !((p < kps_pkg::COLUMNS) && (phase_nxt == kps_pkg::PHASE_W'(p)));
    end
  end

  assign result.column_drive = drive;
  assign result.event_flags  = events_nxt;
  assign result.key_valid    = key_valid;
  assign result.key_code     = key_valid ? first_idx[kps_pkg::CODE_W-1:0] : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= '0;
      armed_r  <= 1'b0;
      events_r <= '0;
      for (int c = 0; c < kps_pkg::COLUMNS; c++) begin
        mask_r[c] <= '0;
      end
    end else if (fire) begin
      phase_r  <= phase_nxt;
      armed_r  <= armed_nxt;
      events_r <= events_nxt;
      for (int c = 0; c < kps_pkg::COLUMNS; c++) begin
        mask_r[c] <= mask_nxt[c];
      end
    end
  end

endmodule

// ===== rtl/kps_out_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keypad scanner result register
// Holds one result item until the downstream side takes it.
// ----------------------------------------------------------------------------
module kps_out_stage (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 res_valid,
  output logic                 res_stall,
  input  kps_pkg::kps_result_t res,
  output logic                 out_valid,
  input  logic                 out_stall,
  output kps_pkg::kps_result_t out_res
);

  logic                 valid_r;
  kps_pkg::kps_result_t res_r;
  logic                 load;

  assign res_stall = valid_r && out_stall;
  assign load      = !res_stall;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && res_valid) begin
      res_r <= res;
    end
  end

endmodule

// ===== rtl/kps_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keypad scanner port checker
// Watches the top-level ports of the keypad scanner core.
// ----------------------------------------------------------------------------
module kps_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [kps_pkg::DRIVE_PINS-1:0] out_column_drive,
  input logic [kps_pkg::EVENT_BITS-1:0] out_event_flags,
  input logic                           out_key_valid,
  input logic [kps_pkg::CODE_W-1:0]     out_key_code
);

  // A newly latched key must show up in the event flags of the same item.
  a_key_in_flags: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_key_valid) |-> out_event_flags[out_key_code])
    else $error("latched key missing from event flags");

  a_code_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_key_valid) |-> (out_key_code == '0))
    else $error("key code nonzero without a key event");

  // At most one column is driven low at a time.
  a_one_column: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $onehot0(~out_column_drive))
    else $error("more than one column driven");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_column_drive)
      && $stable(out_event_flags) && $stable(out_key_valid) && $stable(out_key_code)))
    else $error("stalled result item changed");

endmodule

bind matrix_keypad_scanner_core kps_checker u_kps_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_column_drive (out_column_drive),
  .out_event_flags  (out_event_flags),
  .out_key_valid    (out_key_valid),
  .out_key_code     (out_key_code)
);

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Matrix keypad scanner testbench
// Drives scan ticks into the keypad scanner core, with full scan cycles of
// released and pressed keys, held keys, multi-key presses and misaligned
// noise. Each result item is compared with a tick-by-tick software scanner
// under several sender and receiver idling mixes.
// ----------------------------------------------------------------------------
module testbench;

  localparam int QUIET_LIMIT = 4000;
  localparam int SCAN_TICKS  = kps_pkg::COLUMNS + 1;

  class keypad_scan_tracker;
    logic [kps_pkg::PHASE_W-1:0]    phase;
    logic [kps_pkg::ROW_PINS-1:0]   pressed_rows [kps_pkg::COLUMNS];
    bit                             release_armed;
    logic [kps_pkg::EVENT_BITS-1:0] flags;
    kps_pkg::kps_result_t           expected_scans [$];
    int                             errors;
    int                             ticks;
    int                             checked;
    int                             keys;

    function new();
      phase = '0;
      foreach (pressed_rows[c]) pressed_rows[c] = '0;
      release_armed = 1'b0;
      flags = '0;
      errors = 0;
      ticks = 0;
      checked = 0;
      keys = 0;
    endfunction

    function void note_tick(logic [kps_pkg::ROW_PINS-1:0] levels,
                            logic [kps_pkg::EVENT_BITS-1:0] ack);
      kps_pkg::kps_result_t scan;
      bit any_pressed;
      bit found;
      int c;
      int r;
      int idx;
      scan = '0;
      ticks++;
      flags = flags & ~ack;
      if (phase < kps_pkg::COLUMNS) begin
        pressed_rows[phase] = ~levels & kps_pkg::ROW_ENABLE;
        phase = phase + 1'b1;
      end else begin
        any_pressed = 1'b0;
        foreach (pressed_rows[k]) begin
          if (pressed_rows[k] != '0) any_pressed = 1'b1;
        end
        if (!any_pressed) begin
          release_armed = 1'b1;
        end else if (release_armed) begin
          release_armed = 1'b0;
          found = 1'b0;
          for (c = 0; c < kps_pkg::COLUMNS && !found; c++) begin
            for (r = 0; r < kps_pkg::ROW_PINS && !found; r++) begin
              if (pressed_rows[c][r]) begin
                found = 1'b1;
                idx = c * kps_pkg::ROWS + r;
                if (idx < kps_pkg::EVENT_BITS) begin
                  flags[idx] = 1'b1;
                  scan.key_valid = 1'b1;
                  scan.key_code = kps_pkg::CODE_W'(idx);
                  keys++;
                end
              end
            end
          end
        end
        phase = '0;
        foreach (pressed_rows[k]) pressed_rows[k] = '0;
      end
      scan.column_drive = '1;
      if (phase < kps_pkg::COLUMNS && phase < kps_pkg::DRIVE_PINS) begin
        scan.column_drive[phase] = 1'b0;
      end
      scan.event_flags = flags;
      expected_scans.push_back(scan);
    endfunction

    function void check_scan_result(logic [kps_pkg::DRIVE_PINS-1:0] drive,
                                    logic [kps_pkg::EVENT_BITS-1:0] events,
                                    logic valid, logic [kps_pkg::CODE_W-1:0] code);
      kps_pkg::kps_result_t scan;
      if (expected_scans.size() == 0) begin
        $error("Result item arrived with no tick awaiting one.");
        errors++;
        return;
      end
      scan = expected_scans.pop_front();
      checked++;
      if (drive !== scan.column_drive) begin
        $error("column_drive: expected %h, got %h", scan.column_drive, drive);
        errors++;
      end
      if (events !== scan.event_flags) begin
        $error("event_flags: expected %h, got %h", scan.event_flags, events);
        errors++;
      end
      if (valid !== scan.key_valid) begin
        $error("key_valid: expected %b, got %b", scan.key_valid, valid);
        errors++;
      end
      if (code !== scan.key_code) begin
        $error("key_code: expected %0d, got %0d", scan.key_code, code);
        errors++;
      end
    endfunction
  endclass

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic [kps_pkg::ROW_PINS-1:0]   in_row_levels = '1;
  logic [kps_pkg::EVENT_BITS-1:0] in_event_ack = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic [kps_pkg::DRIVE_PINS-1:0] out_column_drive;
  logic [kps_pkg::EVENT_BITS-1:0] out_event_flags;
  logic                           out_key_valid;
  logic [kps_pkg::CODE_W-1:0]     out_key_code;

  keypad_scan_tracker tracker;
  int quiet_cycles = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int sent = 0;
  int idle_plan [5] = '{0, 85, 0, 38, 0};
  int stall_plan [5] = '{0, 0, 85, 38, 0};

  matrix_keypad_scanner_core u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_row_levels    (in_row_levels),
    .in_event_ack     (in_event_ack),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_column_drive (out_column_drive),
    .out_event_flags  (out_event_flags),
    .out_key_valid    (out_key_valid),
    .out_key_code     (out_key_code)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && tracker != null) begin
      if (in_valid && !in_stall) tracker.note_tick(in_row_levels, in_event_ack);
      if (out_valid && !out_stall) begin
        tracker.check_scan_result(out_column_drive, out_event_flags, out_key_valid,
                                  out_key_code);
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("Watchdog expired after %0d cycles without progress.", QUIET_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

  function automatic logic [kps_pkg::EVENT_BITS-1:0] random_ack();
    int pick;
    pick = $urandom_range(99);
    if (pick < 70) return '0;
    if (pick < 90) return kps_pkg::EVENT_BITS'($urandom);
    if (pick < 95) return '1;
    return kps_pkg::EVENT_BITS'(1) << $urandom_range(kps_pkg::EVENT_BITS - 1);
  endfunction

  task automatic send_tick(logic [kps_pkg::ROW_PINS-1:0] levels,
                           logic [kps_pkg::EVENT_BITS-1:0] ack);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_row_levels <= levels;
    in_event_ack <= ack;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  // One full scan cycle: the column ticks carry the pressed keys, the last
  // tick is the decode tick whose row levels are ignored.
  task automatic send_scan(logic [kps_pkg::EVENT_BITS-1:0] pressed, bit rand_ack,
                           logic [kps_pkg::EVENT_BITS-1:0] decode_ack);
    int c;
    for (c = 0; c < kps_pkg::COLUMNS; c++) begin
      send_tick(~pressed[c*kps_pkg::ROW_PINS +: kps_pkg::ROW_PINS],
                rand_ack ? random_ack() : '0);
    end
    send_tick(kps_pkg::ROW_PINS'($urandom_range(15)), rand_ack ? random_ack() : decode_ack);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.expected_scans.size() != 0) @(posedge clk);
  endtask

  task automatic run_random(int target);
    int pick;
    while (sent < target) begin
      pick = $urandom_range(99);
      if (pick < 35) begin
        send_scan('0, 1'b1, '0);
      end else if (pick < 70) begin
        send_scan(kps_pkg::EVENT_BITS'(1) << $urandom_range(kps_pkg::EVENT_BITS - 1),
                  1'b1, '0);
      end else if (pick < 85) begin
        send_scan(kps_pkg::EVENT_BITS'($urandom), 1'b1, '0);
      end else begin
        repeat ($urandom_range(6, 1)) begin
          send_tick(kps_pkg::ROW_PINS'($urandom_range(15)), random_ack());
        end
        while (sent % SCAN_TICKS != 0) begin
          send_tick(kps_pkg::ROW_PINS'($urandom_range(15)), random_ack());
        end
      end
    end
  endtask

  initial begin
    tracker = new();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_scan(16'h0000, 1'b0, 16'h0000);
    send_scan(16'h0001, 1'b0, 16'h0000);
    send_scan(16'hF00F, 1'b0, 16'h0000);
    send_scan(16'h0000, 1'b0, 16'h0001);
    send_scan(16'h88C0, 1'b0, 16'hFFFF);
    drain();

    for (int s = 0; s < 5; s++) begin
      idle_pct = idle_plan[s];
      stall_pct = stall_plan[s];
      run_random(sent + 255);
      drain();
    end
    stall_pct = 0;
    idle_pct = 0;
    repeat (8) @(posedge clk);

    $display("Covered %0d scan ticks and %0d result items with %0d key events latched,",
             tracker.ticks, tracker.checked, tracker.keys);
    $display("across held, released, multi-key and misaligned scans under mixed idling.");
    if (tracker.errors == 0 && tracker.expected_scans.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
